// ===== rtl/cd2_pkg.sv =====
`default_nettype none
package cd2_pkg;

  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam int              TAYLOR_TERMS = 12;
  localparam int              COEF_BITS    = 24;

  // Taylor term divisors (2t)(2t+1) for sine and (2t-1)(2t) for cosine
  localparam logic [TAYLOR_TERMS-1:0][9:0] SIN_DIV = {
    10'd506, 10'd420, 10'd342, 10'd272, 10'd210, 10'd156,
    10'd110, 10'd72,  10'd42,  10'd20,  10'd6,   10'd1
  };
  localparam logic [TAYLOR_TERMS-1:0][9:0] COS_DIV = {
    10'd462, 10'd380, 10'd306, 10'd240, 10'd182, 10'd132,
    10'd90,  10'd56,  10'd30,  10'd12,  10'd2,   10'd1
  };

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SETUP,
    BK_MAC,
    BK_DRAIN,
    BK_DIV,
    BK_OUT
  } cd2_state_t;

  typedef struct packed {
    logic bank;
    logic dir;
  } cd2_job_t;

  typedef struct packed {
    logic [1:0] pend;
    logic [1:0] fifo_cnt;
  } cd2_status_t;

  function automatic logic signed [15:0] q30_to_q15(longint v);
    longint unsigned mag;
    longint r;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    r = longint'((mag + 64'd16384) >> 15);
    if (v < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // cos in the upper half, sin in the lower half; ang is the angle in Q30
  function automatic logic [31:0] tw_entry(longint unsigned ang);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint sn;
    longint cn;
    int cs;
    int ss;
    a = ang;
    cs = 1;
    ss = 1;
    if (a > PI_Q30) begin
      a = (a >= TWO_PI_Q30) ? 64'd0 : TWO_PI_Q30 - a;
      ss = -1;
    end
    if (a > HALF_PI_Q30) begin
      a = PI_Q30 - a;
      cs = -1;
    end
    a2 = (a * a) >> 30;
    term = a;
    sn = longint'(a);
    for (int t = 1; t < TAYLOR_TERMS; t++) begin
      term = ((term * a2) >> 30) / SIN_DIV[t];
      sn = (t % 2 == 1) ? sn - longint'(term) : sn + longint'(term);
    end
    term = ONE_Q30;
    cn = longint'(ONE_Q30);
    for (int t = 1; t < TAYLOR_TERMS; t++) begin
      term = ((term * a2) >> 30) / COS_DIV[t];
      cn = (t % 2 == 1) ? cn - longint'(term) : cn + longint'(term);
    end
    return {q30_to_q15((cs < 0) ? -cn : cn), q30_to_q15((ss < 0) ? -sn : sn)};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/centered_dft_2d_unit.sv =====
// Centered direct 2D DFT over one ROWS x COLS block of complex samples.
// Sample channel (sample_valid/sample_ready): one word per sample, row-major.
// Config channel (cfg_valid/cfg_ready/cfg_data): bit 0 selects forward (0) or
// inverse (1); it is sampled when the last sample of a block is taken.
// Coefficient channel (coef_valid/coef_ready): ROWS*COLS words per block in
// centered row-major order, frame_end high on the last.
// Samples are taken one per cycle into a two-bank sample RAM; a block job is
// queued when its last sample lands, so one further block can load while
// the previous one is transformed. Loading stalls once two blocks are pending.
// Each coefficient accumulates all ROWS*COLS samples on the single complex
// MAC between a setup step and the pipeline drain, then passes the rounding
// stage (inverse also scales by a reciprocal multiply) and the output state.
// The job is popped from the queue before the first coefficient is computed.
// A stalled coef_ready holds the word and the engine.
// Reset clears direction to forward and empties the load count and queue.
`default_nettype none
module centered_dft_2d_unit #(
  parameter int ROWS        = 8,
  parameter int COLS        = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_data,
  input  wire logic                   sample_valid,
  output logic                        sample_ready,
  input  wire logic [SAMPLE_BITS-1:0] sample_real,
  input  wire logic [SAMPLE_BITS-1:0] sample_imag,
  output logic                        coef_valid,
  input  wire logic                   coef_ready,
  output logic signed [23:0]          coef_real,
  output logic signed [23:0]          coef_imag,
  output logic                        frame_end
);
  import cd2_pkg::*;
  localparam int BLOCK = ROWS * COLS;
  localparam int EW    = $clog2(BLOCK);

  logic                    direction;
  logic                    we;
  logic [EW:0]             waddr;
  logic [EW:0]             raddr;
  logic [2*SAMPLE_BITS-1:0] wdata;
  logic [2*SAMPLE_BITS-1:0] rdata;
  logic                    job_valid;
  cd2_job_t                job;
  logic                    job_pop;
  logic                    done;
  cd2_status_t             status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) direction <= 1'b0;
    else if (cfg_valid) direction <= cfg_data;
  end

  cd2_front #(.BLOCK(BLOCK), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk(clk), .rst(rst), .sample_valid(sample_valid), .sample_ready(sample_ready),
    .sample_real(sample_real), .sample_imag(sample_imag), .dir(direction),
    .we(we), .waddr(waddr), .wdata(wdata), .job_valid(job_valid), .job(job),
    .job_pop(job_pop), .done(done), .status(status)
  );

  cd2_ram #(.WIDTH(2 * SAMPLE_BITS), .DEPTH(2 << EW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  cd2_back #(.ROWS(ROWS), .COLS(COLS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job), .job_pop(job_pop),
    .raddr(raddr), .rdata(rdata), .coef_valid(coef_valid), .coef_ready(coef_ready),
    .coef_real(coef_real), .coef_imag(coef_imag), .frame_end(frame_end), .done(done)
  );

  a_pend_max: assert property (@(posedge clk) disable iff (rst)
    status.pend != 2'd3) else $error("pending block count overflow");

  a_fifo_le_pend: assert property (@(posedge clk) disable iff (rst)
    status.fifo_cnt <= status.pend) else $error("queue holds more than pending");

  a_done_pending: assert property (@(posedge clk) disable iff (rst)
    done |-> status.pend != 2'd0) else $error("block done with none pending");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> job_valid) else $error("job popped from empty queue");
endmodule
`default_nettype wire

// ===== rtl/cd2_ram.sv =====
`default_nettype none
module cd2_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/cd2_front.sv =====
`default_nettype none
module cd2_front #(
  parameter int BLOCK       = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            sample_valid,
  output logic                                 sample_ready,
  input  wire logic [SAMPLE_BITS-1:0]          sample_real,
  input  wire logic [SAMPLE_BITS-1:0]          sample_imag,
  input  wire logic                            dir,
  output logic                                 we,
  output logic [$clog2(BLOCK):0]               waddr,
  output logic [2*SAMPLE_BITS-1:0]             wdata,
  output logic                                 job_valid,
  output cd2_pkg::cd2_job_t                    job,
  input  wire logic                            job_pop,
  input  wire logic                            done,
  output cd2_pkg::cd2_status_t                 status
);
  import cd2_pkg::*;
  localparam int EW = $clog2(BLOCK);

  logic [EW-1:0] cnt;
  logic          wb;
  logic [1:0]    pend;
  logic [1:0]    fcnt;
  cd2_job_t      q0;
  cd2_job_t      q1;
  logic          acc;
  logic          push;
  logic          to_head;

  assign sample_ready = (pend != 2'd2);
  assign acc  = sample_valid && sample_ready;
  assign push = acc && (cnt == EW'(BLOCK - 1));
  assign to_head = (fcnt == {1'b0, job_pop});
  assign we    = acc;
  assign waddr = {wb, cnt};
  assign wdata = {sample_real, sample_imag};
  assign job_valid = (fcnt != 2'd0);
  assign job = q0;
  assign status = '{pend: pend, fifo_cnt: fcnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      wb   <= 1'b0;
      pend <= 2'd0;
      fcnt <= 2'd0;
    end else begin
      if (acc) begin
        cnt <= push ? '0 : cnt + 1'b1;
        if (push) wb <= ~wb;
      end
      pend <= pend + {1'b0, push} - {1'b0, done};
      fcnt <= fcnt + {1'b0, push} - {1'b0, job_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && to_head) q0 <= '{bank: wb, dir: dir};
    else if (job_pop) q0 <= q1;
    if (push && !to_head) q1 <= '{bank: wb, dir: dir};
  end
endmodule
`default_nettype wire

// ===== rtl/cd2_div.sv =====
`default_nettype none
module cd2_div #(
  parameter int ACCW  = 39,
  parameter int BLOCK = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic                   dir,
  input  wire logic signed [ACCW-1:0] acc,
  output logic                        ready,
  output logic signed [23:0]          result
);
  import cd2_pkg::*;
  localparam int TW = ACCW + 1 - 15;
  localparam int QW = (TW > 25) ? TW : 25;
  localparam int LB = $clog2(BLOCK);
  localparam int SH = TW + LB;
  localparam int MW = TW + 1;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + BLOCK - 1) / BLOCK);

  logic [ACCW-1:0]  mag;
  logic [ACCW:0]    sum;
  logic [TW-1:0]    quo;
  logic [TW+MW-1:0] prod;
  logic             neg;
  logic             busy;
  logic [QW-1:0]    qx;

  assign mag = acc[ACCW-1] ? ACCW'(-acc) : ACCW'(acc);
  assign sum = {1'b0, mag} + (dir ? (ACCW+1)'(16384 * BLOCK) : (ACCW+1)'(16384));
  assign prod = {{MW{1'b0}}, quo} * {{TW{1'b0}}, RECIP};
  assign qx = QW'(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      ready <= 1'b0;
    end else if (start) begin
      busy  <= dir;
      ready <= ~dir;
      quo   <= sum[ACCW:15];
      neg   <= acc[ACCW-1];
    end else if (busy) begin
      quo   <= TW'(prod[TW+MW-1:SH]);
      busy  <= 1'b0;
      ready <= 1'b1;
    end
  end

  always_comb begin
    if (neg) result = (qx > QW'(8388608)) ? 24'sh800000 : 24'(-qx);
    else result = (qx > QW'(8388607)) ? 24'sh7fffff : qx[23:0];
  end
endmodule
`default_nettype wire

// ===== rtl/cd2_back.sv =====
`default_nettype none
module cd2_back #(
  parameter int ROWS        = 8,
  parameter int COLS        = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            job_valid,
  input  cd2_pkg::cd2_job_t                    job,
  output logic                                 job_pop,
  output logic [$clog2(ROWS*COLS):0]           raddr,
  input  wire logic [2*SAMPLE_BITS-1:0]        rdata,
  output logic                                 coef_valid,
  input  wire logic                            coef_ready,
  output logic signed [23:0]                   coef_real,
  output logic signed [23:0]                   coef_imag,
  output logic                                 frame_end,
  output logic                                 done
);
  import cd2_pkg::*;
  localparam int BLOCK = ROWS * COLS;
  localparam int EW    = $clog2(BLOCK);
  localparam int PW    = $clog2(COLS);
  localparam int SB    = SAMPLE_BITS;
  localparam int ACCW  = SB + 17 + EW;
  localparam int N0    = -(COLS / 2);
  localparam int M0    = -(ROWS / 2);
  localparam int DU0   = (((N0 * ROWS) % BLOCK) + BLOCK) % BLOCK;
  localparam int SU0   = (((N0 * N0 * ROWS) % BLOCK) + BLOCK) % BLOCK;
  localparam int CSU   = DU0;
  localparam int DV0   = (((M0 * COLS) % BLOCK) + BLOCK) % BLOCK;
  localparam int SV0   = (((M0 * M0 * COLS) % BLOCK) + BLOCK) % BLOCK;
  localparam int CSV   = DV0;

  function automatic logic [EW-1:0] addm(logic [EW-1:0] a, logic [EW-1:0] b);
    logic [EW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= (EW+1)'(BLOCK)) ? EW'(s - (EW+1)'(BLOCK)) : s[EW-1:0];
  endfunction

  logic [31:0] tw_tab [BLOCK];
  for (genvar g = 0; g < BLOCK; g++) begin : g_tw
    localparam longint unsigned ANG =
      (TWO_PI_Q30 * longint'(g) + longint'(BLOCK / 2)) / longint'(BLOCK);
    localparam logic [31:0] ENTRY = tw_entry(ANG);
    assign tw_tab[g] = ENTRY;
  end

  cd2_state_t state;
  cd2_state_t state_next;
  logic            bank;
  logic            dirr;
  logic [EW-1:0]   idx;
  logic [PW-1:0]   pn;
  logic [PW-1:0]   pu;
  logic [EW-1:0]   cidx;
  logic [EW-1:0]   du, su, dv, sv, erow, e;
  logic [EW-1:0]   k;
  logic [EW-1:0]   k1;
  logic            v1, v2;
  logic signed [SB+15:0] p_cx, p_sy, p_cy, p_sx;
  logic signed [ACCW-1:0] acc_r, acc_i;
  logic signed [15:0] tc, ts;
  logic signed [SB-1:0] xr, xi;
  logic            div_start;
  logic            rdy_r, rdy_i;
  logic signed [23:0] res_r, res_i;
  logic [EW-1:0]   erow_n;
  logic            out_acc;
  logic            issue;

  assign k  = (dirr && e != '0) ? EW'((EW+1)'(BLOCK) - {1'b0, e}) : e;
  assign tc = tw_tab[k1][31:16];
  assign ts = tw_tab[k1][15:0];
  assign xr = rdata[2*SB-1:SB];
  assign xi = rdata[SB-1:0];
  assign raddr = {bank, idx};
  assign erow_n = addm(erow, dv);
  assign out_acc = coef_valid && coef_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (job_valid) state_next = BK_SETUP;
      BK_SETUP: state_next = BK_MAC;
      BK_MAC:   if (idx == EW'(BLOCK - 1)) state_next = BK_DRAIN;
      BK_DRAIN: if (!v1 && !v2) state_next = BK_DIV;
      BK_DIV:   if (rdy_r && rdy_i) state_next = BK_OUT;
      BK_OUT:   if (coef_ready) state_next = (cidx == EW'(BLOCK - 1)) ? BK_IDLE : BK_SETUP;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop    = 1'b0;
    issue      = 1'b0;
    div_start  = 1'b0;
    coef_valid = 1'b0;
    done       = 1'b0;
    unique case (state)
      BK_IDLE:  job_pop = job_valid;
      BK_SETUP: ;
      BK_MAC:   issue = 1'b1;
      BK_DRAIN: div_start = !v1 && !v2;
      BK_DIV:   ;
      BK_OUT: begin
        coef_valid = 1'b1;
        done = coef_ready && (cidx == EW'(BLOCK - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      bank <= job.bank;
      dirr <= job.dir;
      du   <= EW'(DU0);
      su   <= EW'(SU0);
      dv   <= EW'(DV0);
      sv   <= EW'(SV0);
      cidx <= '0;
      pu   <= '0;
    end
    if (state == BK_SETUP) begin
      e     <= addm(su, sv);
      erow  <= addm(su, sv);
      idx   <= '0;
      pn    <= '0;
      acc_r <= '0;
      acc_i <= '0;
    end
    if (issue) begin
      k1  <= k;
      idx <= idx + 1'b1;
      if (pn == PW'(COLS - 1)) begin
        pn   <= '0;
        erow <= erow_n;
        e    <= erow_n;
      end else begin
        pn <= pn + 1'b1;
        e  <= addm(e, du);
      end
    end
    if (v1) begin
      p_cx <= tc * xr;
      p_sy <= ts * xi;
      p_cy <= tc * xi;
      p_sx <= ts * xr;
    end
    if (v2) begin
      acc_r <= acc_r + ACCW'(p_cx) + ACCW'(p_sy);
      acc_i <= acc_i + ACCW'(p_cy) - ACCW'(p_sx);
    end
    if (state == BK_DIV && rdy_r && rdy_i) begin
      coef_real <= res_r;
      coef_imag <= res_i;
      frame_end <= (cidx == EW'(BLOCK - 1));
    end
    if (out_acc) begin
      cidx <= cidx + 1'b1;
      if (pu == PW'(COLS - 1)) begin
        pu <= '0;
        du <= EW'(DU0);
        su <= EW'(SU0);
        dv <= addm(dv, EW'(COLS));
        sv <= addm(sv, EW'(CSV));
      end else begin
        pu <= pu + 1'b1;
        du <= addm(du, EW'(ROWS));
        su <= addm(su, EW'(CSU));
      end
    end
  end

  cd2_div #(.ACCW(ACCW), .BLOCK(BLOCK)) u_div_r (
    .clk(clk), .rst(rst), .start(div_start), .dir(dirr), .acc(acc_r),
    .ready(rdy_r), .result(res_r)
  );

  cd2_div #(.ACCW(ACCW), .BLOCK(BLOCK)) u_div_i (
    .clk(clk), .rst(rst), .start(div_start), .dir(dirr), .acc(acc_i),
    .ready(rdy_i), .result(res_i)
  );
endmodule
`default_nettype wire
